[rtl/u8u16_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types, constants and helper functions of the UTF-8 to UTF-16LE
// transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam logic [15:0] REPLACEMENT = 16'hFFFD;
  localparam logic [15:0] SUR_HI_BASE = 16'hD800;
  localparam logic [15:0] SUR_LO_BASE = 16'hDC00;
  localparam logic [9:0]  SUR_LO_MASK = 10'h3FF;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;
  localparam logic [7:0]  CONT_MASK   = 8'h3F;
  localparam logic [11:0] CAP_RESET   = 12'd1023;

  typedef struct packed {
    logic [2:0][7:0] pend;
    logic [1:0]      cnt;
    logic [11:0]     written;
    logic            ovf;
  } st_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        has_unit;
    logic        last;
    logic        overflowed;
  } res_t;

  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] len;
    if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if ((b & 8'hE0) == 8'hC0) begin
      len = 3'd2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      len = 3'd3;
    end else if ((b & 8'hF8) == 8'hF0) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

  function automatic logic [20:0] decode(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [7:0] b3,
                                         input logic [2:0] len);
    logic [20:0] cp;
    logic [5:0]  c1;
    logic [5:0]  c2;
    logic [5:0]  c3;
    c1 = b1[5:0] & CONT_MASK[5:0];
    c2 = b2[5:0] & CONT_MASK[5:0];
    c3 = b3[5:0] & CONT_MASK[5:0];
    case (len)
      3'd2:    cp = {10'd0, b0[4:0], c1};
      3'd3:    cp = {5'd0, b0[3:0], c1, c2};
      3'd4:    cp = {b0[2:0], c1, c2, c3};
      default: cp = {13'd0, b0};
    endcase
    return cp;
  endfunction

endpackage
`default_nettype wire

[rtl/utf8_to_utf16le_transcoder_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_utf16le_transcoder_core
// Converts a zero-terminated UTF-8 byte stream into UTF-16 code units, with
// a per-string unit capacity and an end marker on the terminator.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake               Payload
// in        sink       in_valid_i/in_stall_o   data_byte_i
// out       source     out_valid_o/out_stall_i code_unit_o, has_unit_o,
//                                              last_o, overflowed_o
// cfg       APB slave  psel/penable/pready     paddr, pwdata, prdata
//
// A byte enters an input register, is decoded from it once the result
// register is free and its results land in a three-entry result register;
// one byte per cycle is taken while each byte yields at most one result
// and the output does not stall. A byte giving two or three results holds
// the input side while the result register drains. Reset clears the decoder
// state and sets the capacity to 1023; no clearing pass is needed.
// ----------------------------------------------------------------------------
module utf8_to_utf16le_transcoder_core import u8u16_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] code_unit_o,
  output logic        has_unit_o,
  output logic        last_o,
  output logic        overflowed_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_CAPACITY = 1'b0;

  logic [11:0] cap_q;
  logic        s1_valid_q, s1_valid_d;
  logic [7:0]  s1_byte_q;
  st_t         st_q;
  st_t         st_next;
  res_t [2:0]  step_res;
  logic [1:0]  step_count;
  logic        buf_free;
  logic        advance;
  logic        in_accept;
  logic        cfg_write;
  res_t        cur_res;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
  assign prdata    = (paddr[2] == REG_CAPACITY) ? {20'd0, cap_q} : 32'd0;

  assign advance    = s1_valid_q && buf_free;
  assign in_stall_o = s1_valid_q && !buf_free;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_accept || (s1_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q      <= CAP_RESET;
      s1_valid_q <= 1'b0;
      st_q       <= '0;
    end else begin
      if (cfg_write) begin
        cap_q <= pwdata[11:0];
      end
      s1_valid_q <= s1_valid_d;
      if (advance) begin
        st_q <= st_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= data_byte_i;
    end
  end

  u8u16_step u_step (
    .byte_i  (s1_byte_q),
    .state_i (st_q),
    .cap_i   (cap_q),
    .state_o (st_next),
    .res_o   (step_res),
    .count_o (step_count)
  );

  u8u16_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_i       (step_res),
    .count_i     (step_count),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (cur_res)
  );

  assign code_unit_o  = cur_res.code_unit;
  assign has_unit_o   = cur_res.has_unit;
  assign last_o       = cur_res.last;
  assign overflowed_o = cur_res.overflowed;

  a_empty_pending_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.cnt == 2'd0) |-> (st_q.pend == '0))
    else $error("pending bytes left behind with an empty count");

  a_bare_marker : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_unit_o) |-> (last_o && code_unit_o == 16'd0))
    else $error("result without a unit is not a clean end marker");

  a_overflow_on_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflowed_o) |-> last_o)
    else $error("overflow flag shown on a result that is not the last");

endmodule
`default_nettype wire

[rtl/u8u16_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_step
// Combinational step: one byte and the decoder state give the next state and
// up to three result entries, with the unit capacity applied.
// ----------------------------------------------------------------------------
module u8u16_step import u8u16_pkg::*; (
  input  logic [7:0]       byte_i,
  input  st_t              state_i,
  input  logic [11:0]      cap_i,
  output st_t              state_o,
  output res_t [2:0]       res_o,
  output logic [1:0]       count_o
);

  logic [2:0]       cand_v;
  logic [2:0][20:0] cand_cp;
  logic [3:0]       res_v;
  logic [3:0][15:0] res_u;
  logic [2:0]       idx;
  logic [12:0]      w;
  logic             ovf;
  logic             term;
  logic [2:0]       lead_len;
  logic [2:0]       len1;
  logic [2:0]       len2;
  logic [7:0]       b1;
  logic [7:0]       b2;
  logic [7:0]       b3;
  logic [20:0]      v;
  logic [2:0]       last_idx;
  st_t              nxt;

  assign term = (byte_i == 8'd0);

  always_comb begin
    cand_v   = '0;
    cand_cp  = '0;
    nxt      = state_i;
    lead_len = seq_len(state_i.pend[0]);
    len1     = seq_len(state_i.pend[1]);
    len2     = seq_len(state_i.pend[2]);
    b1       = (state_i.cnt == 2'd1) ? byte_i : state_i.pend[1];
    b2       = (state_i.cnt == 2'd2) ? byte_i : state_i.pend[2];
    b3       = (state_i.cnt == 2'd3) ? byte_i : 8'd0;
    if (term) begin
      if (state_i.cnt != 2'd0) begin
        cand_v[0]  = 1'b1;
        cand_cp[0] = {5'd0, REPLACEMENT};
      end
      if (state_i.cnt >= 2'd2) begin
        cand_v[1] = 1'b1;
        if (len1 == 3'd1) begin
          cand_cp[1] = {13'd0, state_i.pend[1]};
          if (state_i.cnt == 2'd3) begin
            cand_v[2]  = 1'b1;
            cand_cp[2] = (len2 == 3'd1) ? {13'd0, state_i.pend[2]} : {5'd0, REPLACEMENT};
          end
        end else if (len1 == 3'd2 && state_i.cnt == 2'd3) begin
          cand_cp[1] = decode(state_i.pend[1], state_i.pend[2], 8'd0, 8'd0, 3'd2);
        end else begin
          cand_cp[1] = {5'd0, REPLACEMENT};
          if (state_i.cnt == 2'd3) begin
            cand_v[2]  = 1'b1;
            cand_cp[2] = (len2 == 3'd1) ? {13'd0, state_i.pend[2]} : {5'd0, REPLACEMENT};
          end
        end
      end
    end else if (state_i.cnt == 2'd0) begin
      unique case (seq_len(byte_i))
        3'd1: begin
          cand_v[0]  = 1'b1;
          cand_cp[0] = {13'd0, byte_i};
        end
        3'd0: begin
          cand_v[0]  = 1'b1;
          cand_cp[0] = {5'd0, REPLACEMENT};
        end
        default: begin
          nxt.pend[0] = byte_i;
          nxt.cnt     = 2'd1;
        end
      endcase
    end else if (lead_len < 3'd2 || ({1'b0, state_i.cnt} + 3'd1) >= lead_len) begin
      cand_v[0]  = 1'b1;
      cand_cp[0] = (lead_len < 3'd2) ? {5'd0, REPLACEMENT}
                                     : decode(state_i.pend[0], b1, b2, b3, lead_len);
      nxt.pend   = '0;
      nxt.cnt    = 2'd0;
    end else begin
      case (state_i.cnt)
        2'd1:    nxt.pend[1] = byte_i;
        2'd2:    nxt.pend[2] = byte_i;
        default: nxt.pend[0] = state_i.pend[0];
      endcase
      nxt.cnt = state_i.cnt + 2'd1;
    end
  end

  always_comb begin
    res_v = '0;
    res_u = '0;
    idx   = 3'd0;
    w     = {1'b0, state_i.written};
    ovf   = state_i.ovf;
    v     = '0;
    for (int k = 0; k < 3; k++) begin
      if (cand_v[k]) begin
        if (cand_cp[k] >= SUPP_BASE) begin
          v = cand_cp[k] - SUPP_BASE;
          if (w + 13'd2 <= {1'b0, cap_i}) begin
            res_v[idx[1:0]]         = 1'b1;
            res_u[idx[1:0]]         = SUR_HI_BASE | {5'd0, v[20:10]};
            res_v[idx[1:0] + 2'd1]  = 1'b1;
            res_u[idx[1:0] + 2'd1]  = SUR_LO_BASE | {6'd0, v[9:0] & SUR_LO_MASK};
            idx                     = idx + 3'd2;
            w                       = w + 13'd2;
          end else begin
            ovf = 1'b1;
          end
        end else if (w + 13'd1 <= {1'b0, cap_i}) begin
          res_v[idx[1:0]] = 1'b1;
          res_u[idx[1:0]] = cand_cp[k][15:0];
          idx             = idx + 3'd1;
          w               = w + 13'd1;
        end else begin
          ovf = 1'b1;
        end
      end
    end
  end

  assign last_idx = idx - 3'd1;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      res_o[k].code_unit  = res_u[k];
      res_o[k].has_unit   = res_v[k];
      res_o[k].last       = 1'b0;
      res_o[k].overflowed = 1'b0;
    end
    count_o = idx[1:0];
    state_o = nxt;
    state_o.written = w[11:0];
    state_o.ovf     = ovf;
    if (term) begin
      state_o = '0;
      if (idx == 3'd0) begin
        res_o[0].code_unit  = 16'd0;
        res_o[0].has_unit   = 1'b0;
        res_o[0].last       = 1'b1;
        res_o[0].overflowed = ovf;
        count_o             = 2'd1;
      end else begin
        res_o[last_idx[1:0]].last       = 1'b1;
        res_o[last_idx[1:0]].overflowed = ovf;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/u8u16_outbuf.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_outbuf
// Result register: holds the entries of one step and hands them out one
// transfer at a time.
// ----------------------------------------------------------------------------
module u8u16_outbuf import u8u16_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  res_t [2:0] res_i,
  input  logic [1:0] count_i,
  output logic       free_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output res_t       res_o
);

  res_t [2:0] entries_q;
  logic [1:0] rem_q, rem_d;
  logic [1:0] idx_q, idx_d;
  logic       take;

  assign out_valid_o = (rem_q != 2'd0);
  assign take        = out_valid_o && !out_stall_i;
  assign free_o      = (rem_q == 2'd0) || (rem_q == 2'd1 && take);
  assign res_o       = entries_q[idx_q];

  always_comb begin
    rem_d = rem_q;
    idx_d = idx_q;
    if (load_i) begin
      rem_d = count_i;
      idx_d = 2'd0;
    end else if (take) begin
      rem_d = rem_q - 2'd1;
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 2'd0;
      idx_q <= 2'd0;
    end else begin
      rem_q <= rem_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      entries_q <= res_i;
    end
  end

  a_load_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("result register loaded while results still wait");

  a_index_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q != 2'd0) |-> ({1'b0, idx_q} + {1'b0, rem_q} <= 3'd3))
    else $error("result index runs past the held entries");

endmodule
`default_nettype wire
